>>> design/assert_macros.svh
// assertion macros shared by the trajectory design files
// needs clk and rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define MJT_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen out of reset
`define MJT_NEVER(lbl, cond, msg) \
    `MJT_CHECK(lbl, !(cond), msg)

`endif

>>> design/mjt_pkg.sv
// shared constants, types and register indexes of the quintic trajectory sampler
// no dependencies
package mjt_pkg;

    localparam int FRAC_BITS = 16;
    localparam int VAL_W     = 32;
    localparam int TIME_W    = 24;
    localparam int STAT_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_START_POSITION     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_VELOCITY     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ACCELERATION = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_POSITION       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_END_VELOCITY       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_END_ACCELERATION   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DURATION           = 3'd6;

    localparam logic [TIME_W-1:0] DUR_RESET = 24'd65536;

    localparam logic [STAT_W-1:0] STAT_OK  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_SAT = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BAD = 2'd2;

    localparam logic [VAL_W-1:0] POS_MAX = 32'h7fff_ffff;
    localparam logic [VAL_W-1:0] NEG_MIN = 32'h8000_0000;

    // duration to the fifth power
    localparam int D5_W    = 5 * TIME_W;
    localparam int LIMB_W  = 32;
    localparam int ACC_RAW = (2 * FRAC_BITS + 156 > 210) ? 2 * FRAC_BITS + 156 : 210;
    localparam int LIMBS   = (ACC_RAW + LIMB_W - 1) / LIMB_W;
    localparam int ACC_W   = LIMBS * LIMB_W;
    localparam int PROD_W  = LIMB_W + TIME_W + 1;
    // scaled numerator after the rounding offset and the fixed-point shift
    localparam int NP_W    = ACC_W - 2 * FRAC_BITS;
    localparam int Q_W     = 32;
    localparam int RW      = D5_W + Q_W + 1;
    // multiplier operand of the coefficient sequencer
    localparam int MAC_BW  = 2 * FRAC_BITS + 36;

    typedef struct packed {
        logic signed [VAL_W-1:0] x0;
        logic signed [VAL_W-1:0] v0;
        logic signed [VAL_W-1:0] a0;
        logic signed [VAL_W-1:0] x1;
        logic signed [VAL_W-1:0] v1;
        logic signed [VAL_W-1:0] a1;
        logic [TIME_W-1:0]       dur;
    } cfg_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] k5;
        logic signed [ACC_W-1:0] k4;
        logic signed [ACC_W-1:0] k3;
        logic signed [ACC_W-1:0] k2;
        logic signed [ACC_W-1:0] k1;
        logic signed [ACC_W-1:0] k0;
        logic [D5_W-1:0]         d5;
    } coef_t;

    typedef struct packed {
        logic [RW-1:0]  r;
        logic [Q_W-1:0] q;
        logic           neg;
        logic           over;
    } div_t;

endpackage

>>> design/quintic_min_jerk_trajectory_top.sv
// top level of the minimum-jerk quintic trajectory sampler
// depends on mjt_pkg, mjt_coef_seq, mjt_horner_cell, mjt_div_cell, assert_macros.svh
//
// Configuration is written through cfg_we / cfg_index / cfg_data: start and end
// position, velocity, acceleration (signed Q15.16) and duration (Q8.16).
// Every write restarts the coefficient sequencer, which runs one serial
// multiply of 68 operand bits per coefficient term; in_ready stays low
// meanwhile. The same pass runs after reset.
// Input transfers carry sample_time, one result (position, status) comes
// out for each, in order, through five horner cells of
// two stages, a scaling stage, an overflow stage, 32 division cells (one
// quotient bit per cell) and the output register.
// Throughput is one item per cycle once the coefficients are ready, barring stalls.
// When the receiver stalls, the whole row of cells holds and in_ready drops
// until the output register is taken. Reset empties the pipeline.
// Status: 0 ok, 1 saturated, 2 zero duration (position then 0).
`include "assert_macros.svh"

module quintic_min_jerk_trajectory_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mjt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mjt_pkg::CFG_DAT_W-1:0]       cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [mjt_pkg::TIME_W-1:0]          sample_time,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [mjt_pkg::VAL_W-1:0]    position,
    output logic [mjt_pkg::STAT_W-1:0]          status
);

    localparam int ACC_W  = mjt_pkg::ACC_W;
    localparam int NP_W   = mjt_pkg::NP_W;
    localparam int RW     = mjt_pkg::RW;
    localparam int Q_W    = mjt_pkg::Q_W;
    localparam int D5_W   = mjt_pkg::D5_W;
    localparam int F      = mjt_pkg::FRAC_BITS;
    localparam int TIME_W = mjt_pkg::TIME_W;
    localparam int VAL_W  = mjt_pkg::VAL_W;
    localparam int HCELLS = 5;

    mjt_pkg::cfg_t  cfg_reg;
    mjt_pkg::coef_t coef;
    logic           busy;
    logic           adv, take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x0  <= '0;
            cfg_reg.v0  <= '0;
            cfg_reg.a0  <= '0;
            cfg_reg.x1  <= '0;
            cfg_reg.v1  <= '0;
            cfg_reg.a1  <= '0;
            cfg_reg.dur <= mjt_pkg::DUR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mjt_pkg::CFG_START_POSITION:     cfg_reg.x0  <= cfg_data;
                mjt_pkg::CFG_START_VELOCITY:     cfg_reg.v0  <= cfg_data;
                mjt_pkg::CFG_START_ACCELERATION: cfg_reg.a0  <= cfg_data;
                mjt_pkg::CFG_END_POSITION:       cfg_reg.x1  <= cfg_data;
                mjt_pkg::CFG_END_VELOCITY:       cfg_reg.v1  <= cfg_data;
                mjt_pkg::CFG_END_ACCELERATION:   cfg_reg.a1  <= cfg_data;
                mjt_pkg::CFG_DURATION:           cfg_reg.dur <= cfg_data[TIME_W-1:0];
                default:                         cfg_reg.dur <= cfg_reg.dur;
            endcase
        end
    end

    mjt_coef_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (cfg_we),
        .cfg     (cfg_reg),
        .busy    (busy),
        .coef    (coef)
    );

    logic out_valid_reg;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv && !busy && !cfg_we;
    assign take     = in_valid && in_ready;

    // horner chain
    logic signed [ACC_W-1:0] hacc [HCELLS+1];
    logic [TIME_W-1:0]       hs   [HCELLS+1];
    logic                    hv   [HCELLS+1];
    logic signed [ACC_W-1:0] hk   [HCELLS];

    assign hacc[0] = coef.k5;
    assign hs[0]   = sample_time;
    assign hv[0]   = take;
    assign hk[0]   = coef.k4;
    assign hk[1]   = coef.k3;
    assign hk[2]   = coef.k2;
    assign hk[3]   = coef.k1;
    assign hk[4]   = coef.k0;

    for (genvar c = 0; c < HCELLS; c++)
    begin : g_horner
        mjt_horner_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (hv[c]),
            .acc_in    (hacc[c]),
            .s_in      (hs[c]),
            .k         (hk[c]),
            .out_valid (hv[c+1]),
            .acc_out   (hacc[c+1]),
            .s_out     (hs[c+1])
        );
    end

    // magnitude plus half a unit, then drop the fixed-point scale
    logic                  acc_neg;
    logic [ACC_W-1:0]      acc_mag;
    logic [ACC_W:0]        acc_sum;
    logic                  pre_valid_reg, pre_neg_reg;
    logic [NP_W-1:0]       pre_np_reg;

    assign acc_neg = hacc[HCELLS][ACC_W-1];
    assign acc_mag = acc_neg ? ACC_W'(-hacc[HCELLS]) : ACC_W'(hacc[HCELLS]);
    assign acc_sum = {1'b0, acc_mag} + ((ACC_W+1)'(coef.d5) << (2 * F));

    // quotient of 2^32 or more saturates in any case
    mjt_pkg::div_t   dv   [Q_W+1];
    logic            dvv  [Q_W+1];
    mjt_pkg::div_t   ovf_data_reg;
    logic            ovf_valid_reg;
    logic [NP_W-1:0] ovf_limit;

    assign ovf_limit = NP_W'({coef.d5, {Q_W{1'b0}}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_valid_reg <= 1'b0;
            ovf_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            pre_valid_reg <= hv[HCELLS];
            ovf_valid_reg <= pre_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pre_neg_reg       <= acc_neg;
            pre_np_reg        <= acc_sum[ACC_W:2*F+1];
            ovf_data_reg.r    <= pre_np_reg[RW-1:0];
            ovf_data_reg.q    <= '0;
            ovf_data_reg.neg  <= pre_neg_reg;
            ovf_data_reg.over <= (pre_np_reg >= ovf_limit);
        end
    end

    assign dv[0]  = ovf_data_reg;
    assign dvv[0] = ovf_valid_reg;

    for (genvar j = 0; j < Q_W; j++)
    begin : g_div
        localparam int SH = Q_W - 1 - j;
        logic [RW-1:0] divisor;
        assign divisor = RW'(coef.d5) << SH;
        mjt_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (dvv[j]),
            .in_data   (dv[j]),
            .divisor   (divisor),
            .out_valid (dvv[j+1]),
            .out_data  (dv[j+1])
        );
    end

    // saturation and sign
    mjt_pkg::div_t            fin;
    logic                     fin_over;
    logic [VAL_W-1:0]         fin_mag;
    logic [VAL_W-1:0]         fin_pos;
    logic signed [VAL_W-1:0]  position_reg;
    logic [mjt_pkg::STAT_W-1:0] status_reg;

    assign fin      = dv[Q_W];
    assign fin_over = fin.over ||
                      (fin.neg ? (fin.q > mjt_pkg::NEG_MIN) : (fin.q > mjt_pkg::POS_MAX));
    assign fin_mag  = fin_over ? (fin.neg ? mjt_pkg::NEG_MIN : mjt_pkg::POS_MAX) : fin.q;
    assign fin_pos  = fin.neg ? -fin_mag : fin_mag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= dvv[Q_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (cfg_reg.dur == '0)
            begin
                position_reg <= '0;
                status_reg   <= mjt_pkg::STAT_BAD;
            end
            else
            begin
                position_reg <= fin_pos;
                status_reg   <= fin_over ? mjt_pkg::STAT_SAT : mjt_pkg::STAT_OK;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign position  = position_reg;
    assign status    = status_reg;

    `MJT_NEVER(a_no_take_while_busy, in_ready && busy, "input taken during coefficient pass")
    `MJT_CHECK(a_bad_duration, out_valid && (cfg_reg.dur == '0) |-> (status == mjt_pkg::STAT_BAD) && (position == '0), "zero duration result wrong")
    `MJT_CHECK(a_sat_limit, out_valid && (status == mjt_pkg::STAT_SAT) |-> (position == mjt_pkg::POS_MAX) || (position == mjt_pkg::NEG_MIN), "saturated result off limit")
    `MJT_CHECK(a_stall_holds, !adv |=> $stable(hacc[HCELLS]) && $stable(dv[Q_W]), "pipeline moved while stalled")

endmodule

>>> design/mjt_coef_seq.sv
// coefficient sequencer: bit-serial multiply-accumulate over a fixed op list
// depends on mjt_pkg
module mjt_coef_seq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          restart,
    input  mjt_pkg::cfg_t cfg,
    output logic          busy,
    output mjt_pkg::coef_t coef
);

    localparam int ACC_W   = mjt_pkg::ACC_W;
    localparam int MAC_BW  = mjt_pkg::MAC_BW;
    localparam int CNT_W   = $clog2(MAC_BW);
    localparam int NUM_OPS = 24;
    localparam int PC_W    = 5;
    localparam int F       = mjt_pkg::FRAC_BITS;

    localparam logic [1:0] PH_LOAD  = 2'd0;
    localparam logic [1:0] PH_RUN   = 2'd1;
    localparam logic [1:0] PH_STORE = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    localparam logic [4:0] R_DUR  = 5'd0;
    localparam logic [4:0] R_ONE  = 5'd1;
    localparam logic [4:0] R_D2   = 5'd2;
    localparam logic [4:0] R_D4   = 5'd3;
    localparam logic [4:0] R_D5   = 5'd4;
    localparam logic [4:0] R_H0   = 5'd5;
    localparam logic [4:0] R_H1   = 5'd6;
    localparam logic [4:0] R_H1D  = 5'd7;
    localparam logic [4:0] R_H2D2 = 5'd8;
    localparam logic [4:0] R_M3   = 5'd9;
    localparam logic [4:0] R_M4   = 5'd10;
    localparam logic [4:0] R_M5   = 5'd11;
    localparam logic [4:0] R_K4   = 5'd12;
    localparam logic [4:0] R_K3   = 5'd13;
    localparam logic [4:0] R_K2   = 5'd14;
    localparam logic [4:0] R_K1   = 5'd15;
    localparam logic [4:0] R_K0   = 5'd16;

    localparam logic [4:0] B_DUR = 5'd0;
    localparam logic [4:0] B_D2  = 5'd1;
    localparam logic [4:0] B_DX  = 5'd2;
    localparam logic [4:0] B_NV0 = 5'd3;
    localparam logic [4:0] B_NA0 = 5'd4;
    localparam logic [4:0] B_DV  = 5'd5;
    localparam logic [4:0] B_DA  = 5'd6;
    localparam logic [4:0] B_A0  = 5'd7;
    localparam logic [4:0] B_V0  = 5'd8;
    localparam logic [4:0] B_X0  = 5'd9;
    localparam logic [4:0] B_P1  = 5'd10;
    localparam logic [4:0] B_P6  = 5'd11;
    localparam logic [4:0] B_P10 = 5'd12;
    localparam logic [4:0] B_P14 = 5'd13;
    localparam logic [4:0] B_N2  = 5'd14;
    localparam logic [4:0] B_N6  = 5'd15;
    localparam logic [4:0] B_N8  = 5'd16;
    localparam logic [4:0] B_N15 = 5'd17;

    typedef struct packed {
        logic [4:0] dst;
        logic [4:0] asrc;
        logic [4:0] bsrc;
        logic       keep;
    } op_t;

    function automatic op_t op_lookup(input logic [PC_W-1:0] pc);
        op_t o;
        case (pc)
            5'd0:    o = '{R_D2,   R_DUR,  B_DUR, 1'b0};
            5'd1:    o = '{R_D4,   R_D2,   B_D2,  1'b0};
            5'd2:    o = '{R_D5,   R_D4,   B_DUR, 1'b0};
            5'd3:    o = '{R_H0,   R_ONE,  B_DX,  1'b0};
            5'd4:    o = '{R_H0,   R_DUR,  B_NV0, 1'b1};
            5'd5:    o = '{R_H0,   R_D2,   B_NA0, 1'b1};
            5'd6:    o = '{R_H1,   R_ONE,  B_DV,  1'b0};
            5'd7:    o = '{R_H1,   R_DUR,  B_NA0, 1'b1};
            5'd8:    o = '{R_H1D,  R_H1,   B_DUR, 1'b0};
            5'd9:    o = '{R_H2D2, R_D2,   B_DA,  1'b0};
            5'd10:   o = '{R_M3,   R_H0,   B_P10, 1'b0};
            5'd11:   o = '{R_M3,   R_H1D,  B_N8,  1'b1};
            5'd12:   o = '{R_M3,   R_H2D2, B_P1,  1'b1};
            5'd13:   o = '{R_M4,   R_H0,   B_N15, 1'b0};
            5'd14:   o = '{R_M4,   R_H1D,  B_P14, 1'b1};
            5'd15:   o = '{R_M4,   R_H2D2, B_N2,  1'b1};
            5'd16:   o = '{R_M5,   R_H0,   B_P6,  1'b0};
            5'd17:   o = '{R_M5,   R_H1D,  B_N6,  1'b1};
            5'd18:   o = '{R_M5,   R_H2D2, B_P1,  1'b1};
            5'd19:   o = '{R_K4,   R_M4,   B_DUR, 1'b0};
            5'd20:   o = '{R_K3,   R_M3,   B_D2,  1'b0};
            5'd21:   o = '{R_K2,   R_D5,   B_A0,  1'b0};
            5'd22:   o = '{R_K1,   R_D5,   B_V0,  1'b0};
            5'd23:   o = '{R_K0,   R_D5,   B_X0,  1'b0};
            default: o = '{R_K0,   R_D5,   B_X0,  1'b0};
        endcase
        return o;
    endfunction

    logic [1:0]              phase_reg, phase_next;
    logic [PC_W-1:0]         pc_reg, pc_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [ACC_W-1:0]        ash_reg, ash_next;
    logic [MAC_BW-1:0]       b_reg, b_next;

    logic signed [ACC_W-1:0] d2_reg, d4_reg, d5_reg, h0_reg, h1_reg, h1d_reg, h2d2_reg;
    logic signed [ACC_W-1:0] m3_reg, m4_reg, m5_reg, k4_reg, k3_reg, k2_reg, k1_reg, k0_reg;

    op_t                     op;
    logic [ACC_W-1:0]        a_val;
    logic [MAC_BW-1:0]       b_val;
    logic signed [MAC_BW-1:0] x0_e, v0_e, a0_e, x1_e, v1_e, a1_e;
    logic                    last;

    assign op   = op_lookup(pc_reg);
    assign last = (cnt_reg == CNT_W'(MAC_BW - 1));

    assign x0_e = MAC_BW'(cfg.x0);
    assign v0_e = MAC_BW'(cfg.v0);
    assign a0_e = MAC_BW'(cfg.a0);
    assign x1_e = MAC_BW'(cfg.x1);
    assign v1_e = MAC_BW'(cfg.v1);
    assign a1_e = MAC_BW'(cfg.a1);

    always_comb
    begin
        case (op.asrc)
            R_DUR:   a_val = ACC_W'(cfg.dur);
            R_ONE:   a_val = ACC_W'(1);
            R_D2:    a_val = d2_reg;
            R_D4:    a_val = d4_reg;
            R_D5:    a_val = d5_reg;
            R_H0:    a_val = h0_reg;
            R_H1:    a_val = h1_reg;
            R_H1D:   a_val = h1d_reg;
            R_H2D2:  a_val = h2d2_reg;
            R_M3:    a_val = m3_reg;
            R_M4:    a_val = m4_reg;
            default: a_val = m5_reg;
        endcase
    end

    always_comb
    begin
        case (op.bsrc)
            B_DUR:   b_val = MAC_BW'(cfg.dur);
            B_D2:    b_val = d2_reg[MAC_BW-1:0];
            B_DX:    b_val = (x1_e - x0_e) << (2 * F + 1);
            B_NV0:   b_val = -(v0_e << (F + 1));
            B_NA0:   b_val = -a0_e;
            B_DV:    b_val = (v1_e - v0_e) << F;
            B_DA:    b_val = a1_e - a0_e;
            B_A0:    b_val = a0_e;
            B_V0:    b_val = v0_e << (F + 1);
            B_X0:    b_val = x0_e << (2 * F + 1);
            B_P1:    b_val = MAC_BW'(1);
            B_P6:    b_val = MAC_BW'(6);
            B_P10:   b_val = MAC_BW'(10);
            B_P14:   b_val = MAC_BW'(14);
            B_N2:    b_val = MAC_BW'(-2);
            B_N6:    b_val = MAC_BW'(-6);
            B_N8:    b_val = MAC_BW'(-8);
            B_N15:   b_val = MAC_BW'(-15);
            default: b_val = '0;
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        pc_next    = pc_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        ash_next   = ash_reg;
        b_next     = b_reg;
        case (phase_reg)
            PH_LOAD:
            begin
                if (!op.keep)
                begin
                    acc_next = '0;
                end
                ash_next   = a_val;
                b_next     = b_val;
                cnt_next   = '0;
                phase_next = PH_RUN;
            end
            PH_RUN:
            begin
                // top bit of the operand carries negative weight
                if (b_reg[0])
                begin
                    acc_next = last ? acc_reg - $signed(ash_reg) : acc_reg + $signed(ash_reg);
                end
                ash_next = ash_reg << 1;
                b_next   = b_reg >> 1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (last)
                begin
                    phase_next = PH_STORE;
                end
            end
            PH_STORE:
            begin
                if (pc_reg == PC_W'(NUM_OPS - 1))
                begin
                    phase_next = PH_DONE;
                end
                else
                begin
                    pc_next    = pc_reg + PC_W'(1);
                    phase_next = PH_LOAD;
                end
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase
        if (restart)
        begin
            phase_next = PH_LOAD;
            pc_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LOAD;
            pc_reg    <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            pc_reg    <= pc_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        ash_reg <= ash_next;
        b_reg   <= b_next;
        if (phase_reg == PH_STORE)
        begin
            case (op.dst)
                R_D2:    d2_reg   <= acc_reg;
                R_D4:    d4_reg   <= acc_reg;
                R_D5:    d5_reg   <= acc_reg;
                R_H0:    h0_reg   <= acc_reg;
                R_H1:    h1_reg   <= acc_reg;
                R_H1D:   h1d_reg  <= acc_reg;
                R_H2D2:  h2d2_reg <= acc_reg;
                R_M3:    m3_reg   <= acc_reg;
                R_M4:    m4_reg   <= acc_reg;
                R_M5:    m5_reg   <= acc_reg;
                R_K4:    k4_reg   <= acc_reg;
                R_K3:    k3_reg   <= acc_reg;
                R_K2:    k2_reg   <= acc_reg;
                R_K1:    k1_reg   <= acc_reg;
                R_K0:    k0_reg   <= acc_reg;
                default: k0_reg   <= k0_reg;
            endcase
        end
    end

    assign busy    = (phase_reg != PH_DONE);
    assign coef.k5 = m5_reg;
    assign coef.k4 = k4_reg;
    assign coef.k3 = k3_reg;
    assign coef.k2 = k2_reg;
    assign coef.k1 = k1_reg;
    assign coef.k0 = k0_reg;
    assign coef.d5 = d5_reg[mjt_pkg::D5_W-1:0];

endmodule

>>> design/mjt_horner_cell.sv
// one horner step: acc * sample time + coefficient, two register stages
// depends on mjt_pkg
module mjt_horner_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  logic                              in_valid,
    input  logic signed [mjt_pkg::ACC_W-1:0]  acc_in,
    input  logic [mjt_pkg::TIME_W-1:0]        s_in,
    input  logic signed [mjt_pkg::ACC_W-1:0]  k,
    output logic                              out_valid,
    output logic signed [mjt_pkg::ACC_W-1:0]  acc_out,
    output logic [mjt_pkg::TIME_W-1:0]        s_out
);

    localparam int ACC_W  = mjt_pkg::ACC_W;
    localparam int LIMBS  = mjt_pkg::LIMBS;
    localparam int LIMB_W = mjt_pkg::LIMB_W;
    localparam int PROD_W = mjt_pkg::PROD_W;

    logic signed [PROD_W-1:0] prod_next [LIMBS];
    logic signed [PROD_W-1:0] prod_reg  [LIMBS];
    logic                     v1_reg, v2_reg;
    logic [mjt_pkg::TIME_W-1:0] s1_reg, s2_reg;
    logic [ACC_W-1:0]         ev, od, term, acc_next;
    logic signed [ACC_W-1:0]  acc_reg;

    // partial products per limb, only the top limb is signed
    always_comb
    begin
        for (int i = 0; i < LIMBS; i++)
        begin
            if (i == LIMBS - 1)
            begin
                prod_next[i] = $signed(acc_in[LIMB_W*i +: LIMB_W]) * $signed({1'b0, s_in});
            end
            else
            begin
                prod_next[i] = $signed({1'b0, acc_in[LIMB_W*i +: LIMB_W]})
                               * $signed({1'b0, s_in});
            end
        end
    end

    // even and odd limb products do not overlap, so they pack into two words
    always_comb
    begin
        ev = '0;
        od = '0;
        for (int i = 0; i < LIMBS; i++)
        begin
            term = {{(ACC_W-PROD_W){1'b0}}, prod_reg[i]} << (LIMB_W * i);
            if (i % 2 == 0)
            begin
                ev = ev | term;
            end
            else
            begin
                od = od | term;
            end
        end
        acc_next = ev + od + k;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < LIMBS; i++)
            begin
                prod_reg[i] <= prod_next[i];
            end
            s1_reg  <= s_in;
            s2_reg  <= s1_reg;
            acc_reg <= acc_next;
        end
    end

    assign out_valid = v2_reg;
    assign acc_out   = acc_reg;
    assign s_out     = s2_reg;

endmodule

>>> design/mjt_div_cell.sv
// one restoring division step: compare, subtract and shift in a quotient bit
// depends on mjt_pkg
module mjt_div_cell (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  logic                     in_valid,
    input  mjt_pkg::div_t            in_data,
    input  logic [mjt_pkg::RW-1:0]   divisor,
    output logic                     out_valid,
    output mjt_pkg::div_t            out_data
);

    logic          valid_reg;
    mjt_pkg::div_t data_reg, data_next;
    logic          ge;

    assign ge = (in_data.r >= divisor);

    always_comb
    begin
        data_next      = in_data;
        data_next.r    = ge ? in_data.r - divisor : in_data.r;
        data_next.q    = {in_data.q[mjt_pkg::Q_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
